[src/lbct_pkg.sv]
// ---------------------------------------------------------------------------
// lbct_pkg: shared types and constants for the LFU block cache tag engine
// Widths, request kinds, the scan token that walks the cell row, and the
// write beat broadcast to the cells.
// ---------------------------------------------------------------------------
package lbct_pkg;

   localparam int NUM_SLOTS  = 64;
   localparam int IDX_W      = $clog2(NUM_SLOTS);
   localparam int FILL_W     = $clog2(NUM_SLOTS + 1);
   localparam int TAG_W      = 31;
   localparam int CNT_W      = 16;
   localparam int TOT_W      = 32;
   localparam int KIND_W     = 2;
   localparam int SLOT_OUT_W = 6;
   localparam int FILL_OUT_W = 7;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 80;

   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic [CNT_W-1:0] CEILING_RESET = 16'd255;

   // token that travels one cell per cycle, collecting search results
   typedef struct packed {
      logic             active;
      logic [TAG_W-1:0] tag;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic [CNT_W-1:0] hit_cnt;
      logic             empty;
      logic [IDX_W-1:0] empty_idx;
      logic             best_set;
      logic [IDX_W-1:0] best_idx;
      logic [CNT_W-1:0] best_cnt;
   } scan_tok_type;

   // write beat from the controller to the cells
   typedef struct packed {
      logic             clr;
      logic             wr;
      logic             set_tag;
      logic [IDX_W-1:0] idx;
      logic [TAG_W-1:0] tag;
      logic [CNT_W-1:0] cnt;
   } cell_upd_type;

   // raise a use count; halve when the raised value passes the ceiling
   function automatic logic [CNT_W-1:0] raise_count(input logic [CNT_W-1:0] cnt,
                                                    input logic [CNT_W-1:0] ceil);
      logic [CNT_W:0] raised;
      raised = {1'b0, cnt} + {{CNT_W{1'b0}}, 1'b1};
      if (raised > {1'b0, ceil}) begin
         raised = raised >> 1;
      end
      return raised[CNT_W-1:0];
   endfunction

endpackage

[src/lbct_cell.sv]
// ---------------------------------------------------------------------------
// lbct_cell: one slot of the tag row
// Holds tag, valid bit and use count; folds its slot into the passing scan
// token and registers the token toward the next cell.
// ---------------------------------------------------------------------------
module lbct_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [lbct_pkg::IDX_W-1:0] my_index,
   input  lbct_pkg::scan_tok_type    tok_in,
   input  lbct_pkg::cell_upd_type    upd,
   output lbct_pkg::scan_tok_type    tok_out
);
   import lbct_pkg::*;

   logic             valid_ff, valid_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   scan_tok_type     tok_ff, tok_in_next;

   always_comb begin
      tok_in_next = tok_in;
      if (valid_ff && (tag_ff == tok_in.tag) && !tok_in.hit) begin
         tok_in_next.hit     = 1'b1;
         tok_in_next.hit_idx = my_index;
         tok_in_next.hit_cnt = cnt_ff;
      end
      if (!valid_ff && !tok_in.empty) begin
         tok_in_next.empty     = 1'b1;
         tok_in_next.empty_idx = my_index;
      end
      // strict less-than keeps the lowest index on ties
      if (valid_ff && (!tok_in.best_set || (cnt_ff < tok_in.best_cnt))) begin
         tok_in_next.best_set = 1'b1;
         tok_in_next.best_idx = my_index;
         tok_in_next.best_cnt = cnt_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      cnt_in   = cnt_ff;
      if (upd.clr) begin
         valid_in = 1'b0;
      end else if (upd.wr && (upd.idx == my_index)) begin
         cnt_in = upd.cnt;
         if (upd.set_tag) begin
            valid_in = 1'b1;
            tag_in   = upd.tag;
         end
      end
   end

   // only the valid bit and the token's active flag need a reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         tok_ff.active <= tok_in_next.active;
      end
      tag_ff             <= tag_in;
      cnt_ff             <= cnt_in;
      tok_ff.tag         <= tok_in_next.tag;
      tok_ff.hit         <= tok_in_next.hit;
      tok_ff.hit_idx     <= tok_in_next.hit_idx;
      tok_ff.hit_cnt     <= tok_in_next.hit_cnt;
      tok_ff.empty       <= tok_in_next.empty;
      tok_ff.empty_idx   <= tok_in_next.empty_idx;
      tok_ff.best_set    <= tok_in_next.best_set;
      tok_ff.best_idx    <= tok_in_next.best_idx;
      tok_ff.best_cnt    <= tok_in_next.best_cnt;
   end

   assign tok_out = tok_ff;

endmodule

[src/lfu_block_cache_tags.sv]
// ---------------------------------------------------------------------------
// lfu_block_cache_tags: tag and LFU replacement engine for a block cache
// Fully associative tag row of NUM_SLOTS cells with lookup, insert and clear.
// ---------------------------------------------------------------------------
// Each request beat (lookup, insert/refresh or clear of a block number) sends
// a scan token down a row of NUM_SLOTS cells, one cell per clock. The token
// picks up the matching slot, the first empty slot and the lowest-index slot
// with the least use count. When it leaves the last cell the controller
// writes the chosen slot, updates the hit/miss/filled totals and loads the
// response register. The token is registered in each cell of the row, then
// latched, then committed once the response register is free or drained.
// A new request is taken once the previous one is committed, even while its
// response beat still waits on rsp_tready. The 512-byte block data lives
// outside, in a memory addressed by the returned slot.
// ---------------------------------------------------------------------------
module lfu_block_cache_tags (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = block_number (bits 30:0), tuser = kind
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lbct_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [lbct_pkg::KIND_W-1:0]         req_tuser,
   // response: tdata = found, slot[6], placed, hit_total[32],
   //           miss_total[32], filled_total[7] (low bit up)
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lbct_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // use ceiling register
   input  logic                                csr_wr_en,
   input  logic [lbct_pkg::CNT_W-1:0]          csr_wr_data
);
   import lbct_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   scan_tok_type          tok_ff, tok_in;
   logic [CNT_W-1:0]      ceiling_ff, ceiling_in;
   logic [TOT_W-1:0]      hit_ff, hit_in;
   logic [TOT_W-1:0]      miss_ff, miss_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   scan_tok_type          tok_chain [NUM_SLOTS+1];
   cell_upd_type          upd;
   logic                  req_acc;
   logic                  commit;
   logic                  found, placed;
   logic [IDX_W-1:0]      slot_idx;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   // commit only when the response register is free or being drained
   assign commit     = (state_ff == ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // head of the chain: fresh token on an accepted beat
   always_comb begin
      tok_chain[0]        = '0;
      tok_chain[0].active = req_acc;
      tok_chain[0].tag    = req_tdata[TAG_W-1:0];
   end

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      lbct_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .my_index (IDX_W'(i)),
         .tok_in   (tok_chain[i]),
         .upd      (upd),
         .tok_out  (tok_chain[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      tok_in   = tok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               kind_in  = req_tuser;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok_chain[NUM_SLOTS].active) begin
               tok_in   = tok_chain[NUM_SLOTS];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // decision, cell write beat and totals
   always_comb begin
      upd      = '0;
      hit_in   = hit_ff;
      miss_in  = miss_ff;
      fill_in  = fill_ff;
      found    = 1'b0;
      placed   = 1'b0;
      slot_idx = '0;
      if (commit) begin
         case (kind_ff)
            KIND_LOOKUP: begin
               if (tok_ff.hit) begin
                  found    = 1'b1;
                  slot_idx = tok_ff.hit_idx;
                  upd.wr   = 1'b1;
                  upd.idx  = tok_ff.hit_idx;
                  upd.cnt  = raise_count(tok_ff.hit_cnt, ceiling_ff);
                  if (hit_ff != '1) begin
                     hit_in = hit_ff + TOT_W'(1);
                  end
               end else if (miss_ff != '1) begin
                  miss_in = miss_ff + TOT_W'(1);
               end
            end
            KIND_INSERT: begin
               if (tok_ff.hit) begin
                  found    = 1'b1;
                  slot_idx = tok_ff.hit_idx;
               end else begin
                  placed      = 1'b1;
                  slot_idx    = tok_ff.empty ? tok_ff.empty_idx : tok_ff.best_idx;
                  upd.wr      = 1'b1;
                  upd.set_tag = 1'b1;
                  upd.idx     = slot_idx;
                  upd.tag     = tok_ff.tag;
                  upd.cnt     = '0;
                  if (tok_ff.empty) begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            end
            KIND_CLEAR: begin
               upd.clr = 1'b1;
               hit_in  = '0;
               miss_in = '0;
               fill_in = '0;
            end
            default: begin
               // unused kind: nothing changes
            end
         endcase
      end
   end

   always_comb begin
      ceiling_in = csr_wr_en ? csr_wr_data : ceiling_ff;
   end

   // response register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (commit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {1'b0, FILL_OUT_W'(fill_in), miss_in, hit_in, placed,
                          SLOT_OUT_W'(slot_idx), found};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ceiling_ff    <= CEILING_RESET;
         hit_ff        <= '0;
         miss_ff       <= '0;
         fill_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ceiling_ff    <= ceiling_in;
         hit_ff        <= hit_in;
         miss_ff       <= miss_in;
         fill_ff       <= fill_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      tok_ff       <= tok_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[bench/lfu_block_cache_tags_checker.sv]
// ---------------------------------------------------------------------------
// lfu_block_cache_tags_checker: response checker for the LFU block cache tags
// Watches the request, response and ceiling ports, keeps its own copy of the
// tag row, use counts and totals, and compares every response beat field by
// field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module lfu_block_cache_tags_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [lbct_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [lbct_pkg::KIND_W-1:0]     req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [lbct_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [lbct_pkg::CNT_W-1:0]      csr_wr_data,
   output int unsigned                     fail_count,
   output int unsigned                     awaited
);
   import lbct_pkg::*;

   // response tdata layout, low bit up
   localparam int SLOT_LSB   = 1;
   localparam int PLACED_LSB = SLOT_LSB + SLOT_OUT_W;
   localparam int HITS_LSB   = PLACED_LSB + 1;
   localparam int MISSES_LSB = HITS_LSB + TOT_W;
   localparam int FILLED_LSB = MISSES_LSB + TOT_W;

   typedef struct packed {
      logic                  found;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  placed;
      logic [TOT_W-1:0]      hits;
      logic [TOT_W-1:0]      misses;
      logic [FILL_OUT_W-1:0] filled;
   } cache_outcome_type;

   logic [TAG_W-1:0] held_tag [NUM_SLOTS];
   logic             held     [NUM_SLOTS];
   logic [CNT_W-1:0] use_cnt  [NUM_SLOTS];
   logic [TOT_W-1:0] hit_sum;
   logic [TOT_W-1:0] miss_sum;
   logic [FILL_W-1:0] fill_sum;
   logic [CNT_W-1:0] ceiling;

   cache_outcome_type outcome_q [$];
   int unsigned       errs;

   initial begin
      errs = 0;
   end

   task automatic wipe_cache();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         held[i]     = 1'b0;
         held_tag[i] = '0;
         use_cnt[i]  = '0;
      end
      hit_sum  = '0;
      miss_sum = '0;
      fill_sum = '0;
   endtask

   function automatic int find_block(input logic [TAG_W-1:0] blk);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (held[i] && held_tag[i] == blk) begin
            return i;
         end
      end
      return -1;
   endfunction

   // first empty slot, else lowest index among the least used
   function automatic int choose_victim();
      int best;
      best = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!held[i]) begin
            return i;
         end
      end
      for (int i = 1; i < NUM_SLOTS; i++) begin
         if (use_cnt[i] < use_cnt[best]) begin
            best = i;
         end
      end
      return best;
   endfunction

   task automatic apply_request(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] blk,
                                output cache_outcome_type res);
      int             at;
      logic [CNT_W:0] raised;
      res = '0;
      case (kind)
         KIND_LOOKUP: begin
            at = find_block(blk);
            if (at >= 0) begin
               raised = {1'b0, use_cnt[at]} + (CNT_W+1)'(1);
               if (raised > {1'b0, ceiling}) begin
                  raised = raised >> 1;
               end
               use_cnt[at] = raised[CNT_W-1:0];
               if (hit_sum != '1) begin
                  hit_sum = hit_sum + TOT_W'(1);
               end
               res.found = 1'b1;
               res.slot  = at[SLOT_OUT_W-1:0];
            end else if (miss_sum != '1) begin
               miss_sum = miss_sum + TOT_W'(1);
            end
         end
         KIND_INSERT: begin
            at = find_block(blk);
            if (at >= 0) begin
               res.found = 1'b1;
            end else begin
               at = choose_victim();
               if (!held[at]) begin
                  fill_sum = fill_sum + FILL_W'(1);
               end
               held[at]     = 1'b1;
               held_tag[at] = blk;
               use_cnt[at]  = '0;
               res.placed   = 1'b1;
            end
            res.slot = at[SLOT_OUT_W-1:0];
         end
         KIND_CLEAR: begin
            wipe_cache();
         end
         default: begin
         end
      endcase
      res.hits   = hit_sum;
      res.misses = miss_sum;
      res.filled = fill_sum[FILL_OUT_W-1:0];
   endtask

   task automatic compare_field(input string name, input logic [TOT_W-1:0] want,
                                input logic [TOT_W-1:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         errs++;
      end
   endtask

   always @(posedge clock) begin : watch
      cache_outcome_type want;
      cache_outcome_type seen;
      if (reset) begin
         wipe_cache();
         ceiling = CEILING_RESET;
         outcome_q.delete();
      end else begin
         if (csr_wr_en) begin
            ceiling = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata[TAG_W-1:0], want);
            outcome_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.found  = rsp_tdata[0];
            seen.slot   = rsp_tdata[SLOT_LSB +: SLOT_OUT_W];
            seen.placed = rsp_tdata[PLACED_LSB];
            seen.hits   = rsp_tdata[HITS_LSB +: TOT_W];
            seen.misses = rsp_tdata[MISSES_LSB +: TOT_W];
            seen.filled = rsp_tdata[FILLED_LSB +: FILL_OUT_W];
            if (outcome_q.size() == 0) begin
               $error("response beat with no request outstanding");
               errs++;
            end else begin
               want = outcome_q.pop_front();
               compare_field("found", TOT_W'(want.found), TOT_W'(seen.found));
               compare_field("slot", TOT_W'(want.slot), TOT_W'(seen.slot));
               compare_field("placed", TOT_W'(want.placed), TOT_W'(seen.placed));
               compare_field("hit_total", want.hits, seen.hits);
               compare_field("miss_total", want.misses, seen.misses);
               compare_field("filled_total", TOT_W'(want.filled), TOT_W'(seen.filled));
            end
         end
      end
      fail_count <= errs;
      awaited    <= outcome_q.size();
   end

endmodule

[bench/tb_lfu_block_cache_tags.sv]
// ---------------------------------------------------------------------------
// tb_lfu_block_cache_tags: stimulus and verdict for the LFU block cache tags
// Drives lookups, inserts, clears and the unused kind with random gaps on
// both channels, rewrites the use ceiling between idle phases, and leaves the
// checking to the checker module instantiated beside the block.
// ---------------------------------------------------------------------------
module tb_lfu_block_cache_tags;
   import lbct_pkg::*;

   // fourth encoding of the kind field; the block must treat it as a no-op
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int IDLE_LIMIT   = 2000;          // cycles with no beat on either side
   localparam int DRAIN_CYCLES = NUM_SLOTS + 16; // one full scan plus margin
   localparam int POOL_SIZE    = 96;            // block numbers in play per phase
   localparam int HOT_SIZE     = 16;            // frequently looked-up subset
   localparam int PHASES       = 7;
   localparam int RANDOM_ITEMS = 145;           // per phase, after the fill burst

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;    // block_number[30:0], bit 31 zero
   logic [KIND_W-1:0]     req_tuser   = '0;    // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;           // found, slot[6], placed, hit_total[32],
                                               // miss_total[32], filled_total[7]
   logic                  csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]      csr_wr_data = '0;

   logic                  no_idle     = 1'b0;  // burst mode: no gaps, no stalls
   int unsigned           fail_count;
   int unsigned           awaited;             // predictions not yet matched
   int unsigned           idle_cycles = 0;
   logic [TAG_W-1:0]      pool [POOL_SIZE];

   lfu_block_cache_tags u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lfu_block_cache_tags_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .awaited     (awaited)
   );

   always #6 clock = ~clock;

   // Gap length in cycles: mostly none or short, now and then longer than a
   // whole scan so that idle time lands on every phase of the walk.
   function automatic int unsigned gap_len();
      int unsigned r;
      if (no_idle) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 82) begin
         return $urandom_range(1, 3);
      end else if (r < 96) begin
         return $urandom_range(4, 16);
      end
      return $urandom_range(30, 90);
   endfunction

   // One request beat. valid stays high after the handshake; the next call
   // either lowers it for a gap or reloads data in the same step.
   task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] blk);
      int unsigned gap;
      gap = gap_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, blk};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending and wait for every outstanding response beat.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
   endtask

   // Ceiling writes only happen with the block idle.
   task automatic write_ceiling(input logic [CNT_W-1:0] val);
      settle();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Response side back-pressure: ready windows alternate with stalls.
   initial begin : ready_driver
      int unsigned span;
      forever begin
         span = no_idle ? 1 : $urandom_range(1, 24);
         rsp_tready <= 1'b1;
         repeat (span) @(posedge clock);
         span = gap_len();
         if (span != 0) begin
            rsp_tready <= 1'b0;
            repeat (span) @(posedge clock);
         end
      end
   end

   // Watchdog: ends the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [CNT_W-1:0]  ceilings [PHASES];
      logic [KIND_W-1:0] kind;
      logic [TAG_W-1:0]  blk;
      int unsigned       r;
      int unsigned       fill_n;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // --- directed: empty cache, first-empty placement, hits, refresh ----
      send_beat(KIND_LOOKUP, '0);                // miss on an empty row
      send_beat(KIND_INSERT, '1);                // goes to slot 0
      send_beat(KIND_INSERT, '0);                // slot 1
      send_beat(KIND_LOOKUP, '1);
      send_beat(KIND_LOOKUP, '1);
      send_beat(KIND_LOOKUP, '0);
      send_beat(KIND_INSERT, '1);                // already held: found, not placed
      send_beat(KIND_UNUSED, 31'h2AAA_AAAA);     // unused kind changes nothing
      send_beat(KIND_UNUSED, 31'h5555_5555);
      send_beat(KIND_LOOKUP, 31'h5555_5555);
      send_beat(KIND_CLEAR, '1);                 // totals and slots back to zero
      send_beat(KIND_LOOKUP, '1);                // miss after clear

      // ceiling zero: every hit halves, count stays pinned at zero
      write_ceiling(16'd0);
      send_beat(KIND_INSERT, 31'h0000_1234);
      send_beat(KIND_INSERT, 31'h0000_4321);
      repeat (3) send_beat(KIND_LOOKUP, 31'h0000_1234);

      // ceiling one: raised count of two halves back to one
      write_ceiling(16'd1);
      repeat (3) send_beat(KIND_LOOKUP, 31'h0000_4321);
      send_beat(KIND_INSERT, 31'h0000_7777);     // empty slot still preferred
      send_beat(KIND_LOOKUP, 31'h0000_7777);

      // --- random phases, one ceiling setting each ------------------------
      ceilings[0] = 16'hFFFF;
      ceilings[1] = 16'd1;
      ceilings[2] = 16'd3;
      ceilings[3] = 16'd0;
      ceilings[4] = CNT_W'($urandom_range(2, 40));
      ceilings[5] = CNT_W'($urandom_range(1, 65535));
      ceilings[6] = CEILING_RESET;

      for (int p = 0; p < PHASES; p++) begin
         write_ceiling(ceilings[p]);
         for (int i = 0; i < POOL_SIZE; i++) begin
            pool[i] = TAG_W'($urandom());
         end
         pool[0] = '0;
         pool[1] = '1;

         // start from a known-empty row and fill most or all of it, so the
         // random part runs against a near-full cache and drives eviction
         send_beat(KIND_CLEAR, TAG_W'($urandom()));
         fill_n = $urandom_range(48, NUM_SLOTS);
         for (int i = 0; i < fill_n; i++) begin
            send_beat(KIND_INSERT, pool[i]);
         end

         for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) begin
               no_idle <= ($urandom_range(0, 3) == 0);
            end
            // occasional full drain mid-phase
            if ($urandom_range(0, 99) == 0) begin
               settle();
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
               blk = pool[$urandom_range(0, HOT_SIZE - 1)];   // skews use counts
            end else if (r < 93) begin
               blk = pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
               blk = TAG_W'($urandom());
            end
            r = $urandom_range(0, 199);
            if (r < 1) begin
               kind = KIND_CLEAR;
            end else if (r < 7) begin
               kind = KIND_UNUSED;
            end else if (r < 110) begin
               kind = KIND_LOOKUP;
            end else begin
               kind = KIND_INSERT;
            end
            send_beat(kind, blk);
         end
         no_idle <= 1'b0;
      end

      // --- wind down ------------------------------------------------------
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[files.f]
src/lbct_pkg.sv
src/lbct_cell.sv
src/lfu_block_cache_tags.sv
bench/lfu_block_cache_tags_checker.sv
bench/tb_lfu_block_cache_tags.sv
